### rtl/lcfc_pkg.sv
// Shared types and constants of the load-cell force conditioner.
package lcfc_pkg;

  localparam int unsigned DivWidth = 50;
  localparam int unsigned DivSteps = DivWidth / 2;
  localparam int unsigned DivCntWidth = $clog2(DivSteps);
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [2:0] ModeSample = 3'd0;
  localparam logic [2:0] ModeCaptureZero = 3'd1;
  localparam logic [2:0] ModeClearZero = 3'd2;
  localparam logic [2:0] ModeResetFilter = 3'd3;
  localparam logic [2:0] ModeHwTare = 3'd4;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusCalZero = 2'd1;
  localparam logic [1:0] StatusOverflow = 2'd2;

  localparam logic [CfgIdxWidth-1:0] CfgAdcOffset = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgCountsPerNewton = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgFilterAlpha = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CfgDeadband = 2'd3;

  localparam logic [23:0] AdcOffsetReset = 24'd0;
  localparam logic [31:0] CountsPerNewtonReset = 32'd2560000;
  localparam logic [16:0] FilterAlphaReset = 17'd32768;
  localparam logic [30:0] DeadbandReset = 31'd1311;
  localparam logic [16:0] AlphaOne = 17'd65536;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [23:0] sample;
    logic [31:0]        time_ms;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] force_res;
    logic signed [31:0] raw_force;
    logic [31:0]        stamp;
  } out_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic check;
    logic zero;
    logic mult;
    logic update;
    logic write;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic filt_go;
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/lcfc_div.sv
// Radix-4 restoring divider for the force scaling, two quotient bits per cycle.
module lcfc_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [lcfc_pkg::DivWidth-1:0]      dividend_i,
  input  logic [31:0]                        divisor_i,
  output logic                               done_o,
  output logic [lcfc_pkg::DivWidth-1:0]      quot_o
);

  logic                               busy_q;
  logic                               done_q;
  logic [lcfc_pkg::DivCntWidth-1:0]   cnt_q;
  logic [lcfc_pkg::DivWidth-1:0]      num_q, num_d;
  logic [31:0]                        rem_q, rem_d;
  logic [32:0]                        t1, t2;
  logic [31:0]                        r1;
  logic                               ge1, ge2;

  always_comb begin
    t1 = {rem_q, num_q[lcfc_pkg::DivWidth-1]};
    ge1 = t1 >= {1'b0, divisor_i};
    r1 = ge1 ? 32'(t1 - {1'b0, divisor_i}) : t1[31:0];
    t2 = {r1, num_q[lcfc_pkg::DivWidth-2]};
    ge2 = t2 >= {1'b0, divisor_i};
    rem_d = ge2 ? 32'(t2 - {1'b0, divisor_i}) : t2[31:0];
    num_d = {num_q[lcfc_pkg::DivWidth-3:0], ge1, ge2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == lcfc_pkg::DivCntWidth'(lcfc_pkg::DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

### rtl/lcfc_dp.sv
// Datapath: configuration, scaling, zeroing, filter, deadband and result register.
module lcfc_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lcfc_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [31:0]                       cfg_data_i,
  input  lcfc_pkg::in_t                     in_i,
  input  lcfc_pkg::dp_cmd_t                 cmd_i,
  output lcfc_pkg::dp_stat_t                stat_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output lcfc_pkg::out_t                    out_o
);

  logic [23:0]                    adc_offset_q;
  logic [31:0]                    cpn_q;
  logic [16:0]                    alpha_q;
  logic [30:0]                    deadband_q;

  logic [2:0]                     mode_q;
  logic [23:0]                    sample_q;
  logic [31:0]                    time_q;
  logic [1:0]                     status_q;
  logic [31:0]                    raw_q;
  logic [31:0]                    zeroed_q;
  logic signed [50:0]             prod_q;
  logic [31:0]                    filt_q;
  logic                           primed_q;
  logic [31:0]                    zp_q;
  logic                           out_valid_q;
  lcfc_pkg::out_t                 out_q;

  logic                           in_scale;
  logic                           scale_mode;
  logic [24:0]                    diff;
  logic [24:0]                    mag;
  logic                           div_done;
  logic [lcfc_pkg::DivWidth-1:0]  quot;
  logic                           ovf;
  logic [32:0]                    zsum;
  logic signed [32:0]             delta;
  logic [16:0]                    alpha_c;
  logic signed [50:0]             rnd;
  logic signed [34:0]             inc;
  logic [35:0]                    fsum;
  logic [31:0]                    filt_d;
  logic [31:0]                    fmag;
  logic                           sample_ok;

  assign in_scale = (in_i.mode == lcfc_pkg::ModeSample) ||
                    (in_i.mode == lcfc_pkg::ModeCaptureZero);
  assign scale_mode = (mode_q == lcfc_pkg::ModeSample) ||
                      (mode_q == lcfc_pkg::ModeCaptureZero);
  assign sample_ok = (mode_q == lcfc_pkg::ModeSample) && (status_q == lcfc_pkg::StatusOk);

  assign diff = {sample_q[23], sample_q} - {adc_offset_q[23], adc_offset_q};
  assign mag = diff[24] ? 25'(~diff + 25'd1) : diff;

  lcfc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({1'b0, mag, 24'd0}),
    .divisor_i  (cpn_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_comb begin
    if (diff[24]) begin
      ovf = (|quot[49:32]) || (quot[31] && (|quot[30:0]));
    end else begin
      ovf = |quot[49:31];
    end
    zsum = {raw_q[31], raw_q} - {zp_q[31], zp_q};
    delta = $signed({zeroed_q[31], zeroed_q}) - $signed({filt_q[31], filt_q});
    alpha_c = (alpha_q > lcfc_pkg::AlphaOne) ? lcfc_pkg::AlphaOne : alpha_q;
    rnd = prod_q + 51'sd32768;
    inc = rnd[50:16];
    fsum = {{4{filt_q[31]}}, filt_q} + {inc[34], inc};
    if (fsum[35:31] == 5'b00000 || fsum[35:31] == 5'b11111) begin
      filt_d = fsum[31:0];
    end else begin
      filt_d = fsum[35] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    fmag = filt_q[31] ? 32'(~filt_q + 32'd1) : filt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adc_offset_q <= lcfc_pkg::AdcOffsetReset;
      cpn_q <= lcfc_pkg::CountsPerNewtonReset;
      alpha_q <= lcfc_pkg::FilterAlphaReset;
      deadband_q <= lcfc_pkg::DeadbandReset;
      zp_q <= '0;
      filt_q <= '0;
      primed_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          lcfc_pkg::CfgAdcOffset: adc_offset_q <= cfg_data_i[23:0];
          lcfc_pkg::CfgCountsPerNewton: cpn_q <= cfg_data_i;
          lcfc_pkg::CfgFilterAlpha: alpha_q <= cfg_data_i[16:0];
          lcfc_pkg::CfgDeadband: deadband_q <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (cmd_i.update) begin
        if (!primed_q) begin
          filt_q <= zeroed_q;
          primed_q <= 1'b1;
        end else begin
          filt_q <= filt_d;
        end
      end
      if (cmd_i.write) begin
        out_valid_q <= 1'b1;
        if (mode_q == lcfc_pkg::ModeCaptureZero && status_q == lcfc_pkg::StatusOk) begin
          zp_q <= raw_q;
          filt_q <= '0;
          primed_q <= 1'b0;
        end else if (mode_q == lcfc_pkg::ModeClearZero || mode_q == lcfc_pkg::ModeHwTare) begin
          zp_q <= '0;
          filt_q <= '0;
          primed_q <= 1'b0;
        end else if (mode_q == lcfc_pkg::ModeResetFilter) begin
          filt_q <= '0;
          primed_q <= 1'b0;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= in_i.mode;
      sample_q <= in_i.sample;
      time_q <= in_i.time_ms;
      raw_q <= '0;
      status_q <= (in_scale && cpn_q == 32'd0) ? lcfc_pkg::StatusCalZero : lcfc_pkg::StatusOk;
    end
    if (cmd_i.check) begin
      if (ovf) begin
        status_q <= lcfc_pkg::StatusOverflow;
        raw_q <= diff[24] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
        raw_q <= diff[24] ? 32'(~quot[31:0] + 32'd1) : quot[31:0];
      end
    end
    if (cmd_i.zero) begin
      if (zsum[32] == zsum[31]) begin
        zeroed_q <= zsum[31:0];
      end else begin
        zeroed_q <= zsum[32] ? 32'h8000_0000 : 32'h7fff_ffff;
      end
    end
    if (cmd_i.mult) begin
      prod_q <= $signed({1'b0, alpha_c}) * delta;
    end
    if (cmd_i.write) begin
      out_q.status <= status_q;
      out_q.raw_force <= raw_q;
      out_q.stamp <= (status_q == lcfc_pkg::StatusOk) ? time_q : 32'd0;
      if (sample_ok && !(fmag < {1'b0, deadband_q})) begin
        out_q.force_res <= filt_q;
      end else begin
        out_q.force_res <= '0;
      end
    end
  end

  assign stat_o.need_div = scale_mode && (status_q == lcfc_pkg::StatusOk);
  assign stat_o.div_done = div_done;
  assign stat_o.filt_go = sample_ok;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_o = out_q;

endmodule

### rtl/lcfc_ctrl.sv
// Controller state machine that sequences one item through the datapath.
module lcfc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lcfc_pkg::dp_stat_t  stat_i,
  output lcfc_pkg::dp_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StStart,
    StDiv,
    StCheck,
    StZero,
    StMult,
    StUpdate,
    StWrite
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      unique case (state_q)
        StIdle: if (in_valid_i) state_q <= StStart;
        StStart: state_q <= stat_i.need_div ? StDiv : StWrite;
        StDiv: if (stat_i.div_done) state_q <= StCheck;
        StCheck: state_q <= StZero;
        StZero: state_q <= stat_i.filt_go ? StMult : StWrite;
        StMult: state_q <= StUpdate;
        StUpdate: state_q <= StWrite;
        StWrite: if (stat_i.out_free) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.load = (state_q == StIdle) && in_valid_i;
    cmd_o.div_start = (state_q == StStart) && stat_i.need_div;
    cmd_o.check = state_q == StCheck;
    cmd_o.zero = state_q == StZero;
    cmd_o.mult = state_q == StMult;
    cmd_o.update = state_q == StUpdate;
    cmd_o.write = (state_q == StWrite) && stat_i.out_free;
  end

  assign in_ready_o = state_q == StIdle;

endmodule

### rtl/load_cell_force_conditioner_core.sv
// Top level of the load-cell force conditioner.
// Each item carries a mode, an averaged ADC reading and a timestamp, and yields
// exactly one result item. A sample item with a nonzero calibration passes
// through the start, divide, check, zero, multiply, update and write steps;
// a zero-capture item or an overflowing sample skips the multiply and update
// steps. The 25-step radix-4 divider scales the offset-removed reading by
// the counts-per-newton calibration. All other items go from the start step
// straight to the write step. The next item is accepted in the cycle after
// the result is written. One item is processed at a time. A finished result
// waits in an output register, so the next item can be accepted while it is
// held. A result that finds the output register still full waits in the
// write step until the receiver takes the older one. Configuration writes
// take effect at once and must only be issued while the block is idle.
module load_cell_force_conditioner_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  lcfc_pkg::in_t                     in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output lcfc_pkg::out_t                    out_o,
  input  logic                              cfg_we_i,
  input  logic [lcfc_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [31:0]                       cfg_data_i
);

  lcfc_pkg::dp_cmd_t  cmd;
  lcfc_pkg::dp_stat_t stat;

  lcfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lcfc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule
